// File: sv/tlfk_pkg.sv
// ---------------------------------------------------------------------------
// tlfk_pkg
// Shared types and constants for the two-link arm forward kinematics block.
// ---------------------------------------------------------------------------
`default_nettype none

package tlfk_pkg;

   // angle resolution: 2**ANGLE_BITS units per turn
   localparam int ANGLE_BITS     = 16;
   // fraction bits of the sine and cosine values
   localparam int TRIG_FRAC_BITS = 15;

   localparam int STEP_W    = 16;
   localparam int LEN_W     = 10;
   localparam int BASE_W    = 11;
   localparam int ELBOW_W   = 13;
   localparam int TIP_W     = 14;
   localparam int POS_W     = 16;

   // CORDIC rotation unit
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_FRAC  = 30;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int XY_W         = CORDIC_FRAC + 3;
   localparam int Z_W          = 32;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // quadrant of the folded angle
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // trig values after quadrant fold can reach +2**TRIG_FRAC_BITS
   localparam int TRIG_W = TRIG_FRAC_BITS + 2;
   localparam int PROD_W = LEN_W + 1 + TRIG_W + 1;

   // elbow start angle: 45 rad as a 32-bit turn fraction, rounded to half units
   localparam logic [63:0] ELBOW_START_TURN32 = 64'd695666329;
   localparam int          ELBOW_SH           = 31 - ANGLE_BITS;
   localparam logic [ANGLE_BITS:0] ELBOW_RESET =
      (ANGLE_BITS + 1)'((ELBOW_START_TURN32 + (64'd1 << (ELBOW_SH - 1))) >> ELBOW_SH);

   // configuration registers
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam logic [1:0] REG_UPPER_LEN = 2'd0;
   localparam logic [1:0] REG_LOWER_LEN = 2'd1;
   localparam logic [1:0] REG_BASE_X    = 2'd2;
   localparam logic [1:0] REG_BASE_Y    = 2'd3;
   localparam logic [BASE_W-1:0] BASE_X_RESET = BASE_W'(400);
   localparam logic [BASE_W-1:0] BASE_Y_RESET = BASE_W'(300);

   // product select for the shared multiplier
   localparam logic [1:0] MUL_EX = 2'd0;
   localparam logic [1:0] MUL_EY = 2'd1;
   localparam logic [1:0] MUL_TX = 2'd2;
   localparam logic [1:0] MUL_TY = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0]  upper_len;
      logic [LEN_W-1:0]  lower_len;
      logic [BASE_W-1:0] base_x;
      logic [BASE_W-1:0] base_y;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITER,
      ST_ROUND,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              iter;
      logic [ITER_W-1:0] iter_idx;
      logic              round;
      logic              mul;
      logic [1:0]        mul_idx;
      logic              load_out;
   } cmd_type;

endpackage

`default_nettype wire

// File: sv/tlfk_csr.sv
// ---------------------------------------------------------------------------
// tlfk_csr
// APB register file: link lengths and base position.
// ---------------------------------------------------------------------------
`default_nettype none

module tlfk_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tlfk_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [tlfk_pkg::DATA_W-1:0]   pwdata,
   output logic      [tlfk_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output tlfk_pkg::csr_type                  csr
);

   tlfk_pkg::csr_type csr_ff;
   tlfk_pkg::csr_type csr_in;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign csr     = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tlfk_pkg::REG_UPPER_LEN: csr_in.upper_len = pwdata[tlfk_pkg::LEN_W-1:0];
            tlfk_pkg::REG_LOWER_LEN: csr_in.lower_len = pwdata[tlfk_pkg::LEN_W-1:0];
            tlfk_pkg::REG_BASE_X:    csr_in.base_x    = pwdata[tlfk_pkg::BASE_W-1:0];
            tlfk_pkg::REG_BASE_Y:    csr_in.base_y    = pwdata[tlfk_pkg::BASE_W-1:0];
            default:                 csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.upper_len <= '0;
         csr_ff.lower_len <= '0;
         csr_ff.base_x    <= tlfk_pkg::BASE_X_RESET;
         csr_ff.base_y    <= tlfk_pkg::BASE_Y_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tlfk_pkg::REG_UPPER_LEN: prdata = tlfk_pkg::DATA_W'(csr_ff.upper_len);
         tlfk_pkg::REG_LOWER_LEN: prdata = tlfk_pkg::DATA_W'(csr_ff.lower_len);
         tlfk_pkg::REG_BASE_X:    prdata = tlfk_pkg::DATA_W'(csr_ff.base_x);
         tlfk_pkg::REG_BASE_Y:    prdata = tlfk_pkg::DATA_W'(csr_ff.base_y);
         default:                 prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/tlfk_ctrl.sv
// ---------------------------------------------------------------------------
// tlfk_ctrl
// Sequencer: accept, CORDIC iterations, rounding, four products, handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module tlfk_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output tlfk_pkg::cmd_type cmd
);

   localparam logic [tlfk_pkg::ITER_W-1:0] ITER_LAST =
      tlfk_pkg::ITER_W'(tlfk_pkg::CORDIC_STEPS - 1);

   tlfk_pkg::state_type          state_ff, state_in;
   logic [tlfk_pkg::ITER_W-1:0]  iter_ff, iter_in;
   logic [1:0]                   mul_ff, mul_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         load_out;

   assign accept    = (state_ff == tlfk_pkg::ST_IDLE) && req_valid;
   assign load_out  = (state_ff == tlfk_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != tlfk_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlfk_pkg::ST_IDLE:  if (accept) state_in = tlfk_pkg::ST_ITER;
         tlfk_pkg::ST_ITER:  if (iter_ff == ITER_LAST) state_in = tlfk_pkg::ST_ROUND;
         tlfk_pkg::ST_ROUND: state_in = tlfk_pkg::ST_MUL;
         tlfk_pkg::ST_MUL:   if (mul_ff == tlfk_pkg::MUL_TY) state_in = tlfk_pkg::ST_DONE;
         tlfk_pkg::ST_DONE:  if (load_out) state_in = tlfk_pkg::ST_IDLE;
         default:            state_in = tlfk_pkg::ST_IDLE;
      endcase
   end

   // counters and output handshake
   always_comb begin
      iter_in      = iter_ff;
      mul_in       = mul_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         iter_in = '0;
      end else if (state_ff == tlfk_pkg::ST_ITER) begin
         iter_in = iter_ff + 1'b1;
      end
      if (state_ff == tlfk_pkg::ST_ROUND) begin
         mul_in = tlfk_pkg::MUL_EX;
      end else if (state_ff == tlfk_pkg::ST_MUL) begin
         mul_in = mul_ff + 1'b1;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.iter_idx = iter_ff;
      cmd.mul_idx  = mul_ff;
      unique case (state_ff)
         tlfk_pkg::ST_IDLE:  cmd.accept   = accept;
         tlfk_pkg::ST_ITER:  cmd.iter     = 1'b1;
         tlfk_pkg::ST_ROUND: cmd.round    = 1'b1;
         tlfk_pkg::ST_MUL:   cmd.mul      = 1'b1;
         tlfk_pkg::ST_DONE:  cmd.load_out = load_out;
         default:            cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlfk_pkg::ST_IDLE;
         iter_ff      <= '0;
         mul_ff       <= tlfk_pkg::MUL_EX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         mul_ff       <= mul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/tlfk_dp.sv
// ---------------------------------------------------------------------------
// tlfk_dp
// Datapath: joint angles, two-lane iterative CORDIC, shared multiplier,
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlfk_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tlfk_pkg::cmd_type                     cmd,
   input  wire tlfk_pkg::csr_type                     csr,
   input  wire logic signed [tlfk_pkg::STEP_W-1:0]    req_angle_step,
   output logic signed [tlfk_pkg::ELBOW_W-1:0]        rsp_elbow_x,
   output logic signed [tlfk_pkg::ELBOW_W-1:0]        rsp_elbow_y,
   output logic signed [tlfk_pkg::TIP_W-1:0]          rsp_tip_x,
   output logic signed [tlfk_pkg::TIP_W-1:0]          rsp_tip_y
);

   localparam int AB       = tlfk_pkg::ANGLE_BITS;
   localparam int XY_W     = tlfk_pkg::XY_W;
   localparam int Z_W      = tlfk_pkg::Z_W;
   localparam int TRIG_W   = tlfk_pkg::TRIG_W;
   localparam int POS_W    = tlfk_pkg::POS_W;
   localparam int PROD_W   = tlfk_pkg::PROD_W;
   localparam int TFB      = tlfk_pkg::TRIG_FRAC_BITS;
   localparam int TRIG_SH  = tlfk_pkg::CORDIC_FRAC - TFB;
   localparam int WIDE_W   = 48;
   localparam int STEP_SHL = (AB >= 16) ? AB - 16 : 0;
   localparam int STEP_SHR = (AB < 16) ? 16 - AB : 0;

   localparam logic signed [XY_W-1:0]   XY_HALF   = XY_W'(64'd1 << (TRIG_SH - 1));
   localparam logic signed [XY_W-1:0]   SAT_HI    = XY_W'((64'd1 << TFB) - 64'd1);
   localparam logic signed [XY_W-1:0]   SAT_LO    = -SAT_HI - XY_W'(1);
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (TFB - 1));
   localparam logic [31:0]              QUAD_OFS  = 32'h20000000;

   // joint angles
   logic [AB-1:0] shoulder_ff, shoulder_in;
   logic [AB:0]   elbow_ff, elbow_in;
   logic signed [WIDE_W-1:0] step_wide;
   logic [AB:0]   delta;
   logic [AB:0]   sum_in;
   logic [31:0]   turn [2];
   logic [31:0]   turn_ofs [2];

   // CORDIC lanes: lane 0 shoulder, lane 1 shoulder + elbow
   logic signed [XY_W-1:0] x_ff [2], x_in [2];
   logic signed [XY_W-1:0] y_ff [2], y_in [2];
   logic signed [Z_W-1:0]  z_ff [2], z_in [2], z_init [2];
   logic [1:0]             q_ff [2], q_init [2];
   logic signed [XY_W-1:0] dx [2], dy [2];
   logic signed [Z_W-1:0]  atan_val;

   // folded trig values
   logic signed [TRIG_W-1:0] cos_ff [2], cos_in [2];
   logic signed [TRIG_W-1:0] sin_ff [2], sin_in [2];
   logic signed [TRIG_W-1:0] rx [2], ry [2];

   // products
   logic [tlfk_pkg::LEN_W-1:0] mul_len;
   logic signed [TRIG_W-1:0]   mul_trig;
   logic signed [POS_W-1:0]    mul_base;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   prod_rnd;
   logic signed [POS_W-1:0]    pos_in;
   logic signed [POS_W-1:0]    ex_ff, ey_ff, tx_ff, ty_ff;

   logic signed [tlfk_pkg::ELBOW_W-1:0] elbow_x_ff, elbow_y_ff;
   logic signed [tlfk_pkg::TIP_W-1:0]   tip_x_ff, tip_y_ff;

   function automatic logic signed [TRIG_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] r;
      r = (v + XY_HALF) >>> TRIG_SH;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return TRIG_W'(r);
   endfunction

   // angle update and CORDIC start values
   always_comb begin
      step_wide   = (WIDE_W'(req_angle_step) <<< STEP_SHL) >>> STEP_SHR;
      delta       = step_wide[AB:0];
      shoulder_in = shoulder_ff + delta[AB-1:0];
      elbow_in    = elbow_ff + delta;
      sum_in      = {shoulder_in, 1'b0} + elbow_in;
      turn[0]     = 32'(shoulder_in) << (32 - AB);
      turn[1]     = 32'(sum_in) << (31 - AB);
      for (int l = 0; l < 2; l++) begin
         // fold into the quadrant around zero
         turn_ofs[l] = turn[l] + QUAD_OFS;
         q_init[l]   = turn_ofs[l][31:30];
         z_init[l]   = $signed({2'b00, turn_ofs[l][29:0]}) - $signed(QUAD_OFS);
      end
   end

   // one CORDIC rotation per cycle on both lanes
   always_comb begin
      atan_val = $signed(tlfk_pkg::ATAN_TABLE[cmd.iter_idx]);
      for (int l = 0; l < 2; l++) begin
         dx[l] = y_ff[l] >>> cmd.iter_idx;
         dy[l] = x_ff[l] >>> cmd.iter_idx;
         if (!z_ff[l][Z_W-1]) begin
            x_in[l] = x_ff[l] - dx[l];
            y_in[l] = y_ff[l] + dy[l];
            z_in[l] = z_ff[l] - atan_val;
         end else begin
            x_in[l] = x_ff[l] + dx[l];
            y_in[l] = y_ff[l] - dy[l];
            z_in[l] = z_ff[l] + atan_val;
         end
      end
   end

   // round, saturate and unfold the quadrant
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rx[l] = round_sat(x_ff[l]);
         ry[l] = round_sat(y_ff[l]);
         case (q_ff[l])
            tlfk_pkg::QUAD_0: begin cos_in[l] = rx[l];  sin_in[l] = ry[l];  end
            tlfk_pkg::QUAD_1: begin cos_in[l] = -ry[l]; sin_in[l] = rx[l];  end
            tlfk_pkg::QUAD_2: begin cos_in[l] = -rx[l]; sin_in[l] = -ry[l]; end
            tlfk_pkg::QUAD_3: begin cos_in[l] = ry[l];  sin_in[l] = -rx[l]; end
            default: begin cos_in[l] = rx[l]; sin_in[l] = ry[l]; end
         endcase
      end
   end

   // shared multiplier: length times trig, rounded half up, plus base or elbow position
   always_comb begin
      unique case (cmd.mul_idx)
         tlfk_pkg::MUL_EX: begin
            mul_len  = csr.upper_len;
            mul_trig = cos_ff[0];
            mul_base = $signed(POS_W'(csr.base_x));
         end
         tlfk_pkg::MUL_EY: begin
            mul_len  = csr.upper_len;
            mul_trig = sin_ff[0];
            mul_base = $signed(POS_W'(csr.base_y));
         end
         tlfk_pkg::MUL_TX: begin
            mul_len  = csr.lower_len;
            mul_trig = cos_ff[1];
            mul_base = ex_ff;
         end
         tlfk_pkg::MUL_TY: begin
            mul_len  = csr.lower_len;
            mul_trig = sin_ff[1];
            mul_base = ey_ff;
         end
         default: begin
            mul_len  = '0;
            mul_trig = '0;
            mul_base = '0;
         end
      endcase
      prod     = $signed({1'b0, mul_len}) * mul_trig;
      prod_rnd = (prod + PROD_HALF) >>> TFB;
      pos_in   = mul_base + POS_W'(prod_rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shoulder_ff <= '0;
         elbow_ff    <= tlfk_pkg::ELBOW_RESET;
      end else if (cmd.accept) begin
         shoulder_ff <= shoulder_in;
         elbow_ff    <= elbow_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (cmd.accept) begin
            x_ff[l] <= tlfk_pkg::CORDIC_GAIN;
            y_ff[l] <= '0;
            z_ff[l] <= z_init[l];
            q_ff[l] <= q_init[l];
         end else if (cmd.iter) begin
            x_ff[l] <= x_in[l];
            y_ff[l] <= y_in[l];
            z_ff[l] <= z_in[l];
         end
         if (cmd.round) begin
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
         end
      end
      if (cmd.mul) begin
         unique case (cmd.mul_idx)
            tlfk_pkg::MUL_EX: ex_ff <= pos_in;
            tlfk_pkg::MUL_EY: ey_ff <= pos_in;
            tlfk_pkg::MUL_TX: tx_ff <= pos_in;
            tlfk_pkg::MUL_TY: ty_ff <= pos_in;
            default:          ex_ff <= ex_ff;
         endcase
      end
      if (cmd.load_out) begin
         elbow_x_ff <= ex_ff[tlfk_pkg::ELBOW_W-1:0];
         elbow_y_ff <= ey_ff[tlfk_pkg::ELBOW_W-1:0];
         tip_x_ff   <= tx_ff[tlfk_pkg::TIP_W-1:0];
         tip_y_ff   <= ty_ff[tlfk_pkg::TIP_W-1:0];
      end
   end

   assign rsp_elbow_x = elbow_x_ff;
   assign rsp_elbow_y = elbow_y_ff;
   assign rsp_tip_x   = tip_x_ff;
   assign rsp_tip_y   = tip_y_ff;

endmodule

`default_nettype wire

// File: sv/two_link_arm_forward_kinematics.sv
// ---------------------------------------------------------------------------
// two_link_arm_forward_kinematics
// Planar two-link arm: joint angle update and elbow/tip pixel positions.
// ---------------------------------------------------------------------------
// Each request carries a signed angle step (65536 units per turn). The step
// is added to the shoulder angle and half of it to the elbow angle; then the
// elbow and tip pixel positions are returned as one response.
// Request channel: req_valid/req_stall with req_angle_step. Response channel:
// rsp_valid/rsp_stall with rsp_elbow_x, rsp_elbow_y, rsp_tip_x, rsp_tip_y.
// The request passes through 24 CORDIC rotations for both joints at once,
// a rounding step, four products on the shared multiplier and a handoff
// to the output register. A new request is not taken while one is in
// progress: req_stall is high whenever the sequencer is not idle.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls longer, the finished result holds in the
// datapath and req_stall stays high until the output register frees up.
// Reset (synchronous, active high) clears the sequencer, sets the shoulder
// angle to zero, the elbow angle to 45 rad and the registers to their
// defaults (lengths 0, base 400,300). Registers are written over APB at
// byte address 4*index; pready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module two_link_arm_forward_kinematics (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [tlfk_pkg::STEP_W-1:0]    req_angle_step,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [tlfk_pkg::ELBOW_W-1:0]        rsp_elbow_x,
   output logic signed [tlfk_pkg::ELBOW_W-1:0]        rsp_elbow_y,
   output logic signed [tlfk_pkg::TIP_W-1:0]          rsp_tip_x,
   output logic signed [tlfk_pkg::TIP_W-1:0]          rsp_tip_y,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [tlfk_pkg::ADDR_W-1:0]           paddr,
   input  wire logic [tlfk_pkg::DATA_W-1:0]           pwdata,
   output logic      [tlfk_pkg::DATA_W-1:0]           prdata,
   output logic                                       pready
);

   tlfk_pkg::csr_type csr;
   tlfk_pkg::cmd_type cmd;

   tlfk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   tlfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tlfk_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr            (csr),
      .req_angle_step (req_angle_step),
      .rsp_elbow_x    (rsp_elbow_x),
      .rsp_elbow_y    (rsp_elbow_y),
      .rsp_tip_x      (rsp_tip_x),
      .rsp_tip_y      (rsp_tip_y)
   );

endmodule

`default_nettype wire

// File: sv/tlfk_checker.sv
// ---------------------------------------------------------------------------
// tlfk_checker
// Port-level checks for the two-link arm block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tlfk_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [tlfk_pkg::ELBOW_W-1:0] rsp_elbow_x,
   input wire logic signed [tlfk_pkg::TIP_W-1:0]   rsp_tip_y
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_elbow_x) && $stable(rsp_tip_y)))
      else $error("response changed while stalled");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: stall right after a request is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // a new response only comes at the end of a busy phase
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without request in flight");

endmodule

bind two_link_arm_forward_kinematics tlfk_checker u_tlfk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_elbow_x (rsp_elbow_x),
   .rsp_tip_y   (rsp_tip_y)
);

`default_nettype wire
